@@ rtl/core/tpr_pkg.sv @@
// Package for the period tachometer: widths, constants, register indexes
// and the command and status bundles between controller and datapath.
// Depends on nothing.
package tpr_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned RPM_W      = 20;
  localparam int unsigned MIN_IV_W   = 20;
  localparam int unsigned TIMEOUT_W  = 26;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 4;

  // Revolutions per minute from a microsecond period: 60 000 000 / period.
  localparam int unsigned DIV_BITS = 26;
  localparam logic [DIV_BITS-1:0] RPM_NUMERATOR = DIV_BITS'(60000000);
  localparam int unsigned DIV_CNT_W = $clog2(DIV_BITS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_BITS - 1);

  // Configuration reset values.
  localparam logic [MIN_IV_W-1:0]  MIN_IV_RESET  = MIN_IV_W'(923);
  localparam logic [RPM_W-1:0]     MAX_RPM_RESET = RPM_W'(65000);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(1000000);

  // Register indexes (word address).
  typedef enum logic [1:0] {
    REG_MIN_INTERVAL = 2'd0,
    REG_MAX_RPM      = 2'd1,
    REG_STOP_TIMEOUT = 2'd2
  } tpr_reg_t;

  // Item kinds.
  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_POLL = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the incoming transaction
    logic poll_upd;    // apply the stop timeout
    logic first_edge;  // first edge: count it, record its time
    logic reject;      // debounced edge: record its time only
    logic accept;      // measured edge: count, store interval, start divider
    logic div_step;    // one restoring division step
    logic clamp;       // write the clamped quotient into the speed
    logic load_out;    // move the result into the output register
  } tpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_poll;
    logic edge_seen;
    logic ge_min;
    logic div_done;
    logic out_free;
  } tpr_sts_t;

endpackage

@@ rtl/core/tpr_ctrl.sv @@
// Controller of the period tachometer: sequences capture, decision,
// division and result hand-over. Depends on tpr_pkg.
module tpr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tpr_pkg::tpr_sts_t sts,
  output tpr_pkg::tpr_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_CLAMP = 5'b01000,
    ST_OUT   = 5'b10000
  } tpr_state_t;

  tpr_state_t state_r, state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        priority if (sts.is_poll) begin
          cmd.poll_upd = 1'b1;
          state_nxt    = ST_OUT;
        end else if (!sts.edge_seen) begin
          cmd.first_edge = 1'b1;
          state_nxt      = ST_OUT;
        end else if (!sts.ge_min) begin
          cmd.reject = 1'b1;
          state_nxt  = ST_OUT;
        end else begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  // An accepted transaction is always evaluated in the following cycle.
  a_capture_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EVAL))
    else $error("accepted transaction not evaluated");

  // The divider finishing leads straight to the clamp.
  a_div_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && sts.div_done) |=> (state_r == ST_CLAMP))
    else $error("division end not followed by clamp");

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over a pending result");

  // Only a measured edge starts the divider.
  a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DIV) |-> $past(cmd.accept))
    else $error("divider entered without a measured edge");
`endif

endmodule

@@ rtl/core/tpr_dp.sv @@
// Datapath of the period tachometer: configuration registers, edge state,
// serial restoring divider and output register. Depends on tpr_pkg.
module tpr_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tpr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tpr_pkg::APB_DATA_W-1:0]    prdata,
  // Input payload
  input  logic                              in_action,
  input  logic [tpr_pkg::TIME_W-1:0]        in_time_us,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tpr_pkg::RPM_W-1:0]         out_rpm,
  output logic                              out_running,
  output logic [tpr_pkg::COUNT_W-1:0]       out_pulse_count,
  output logic [tpr_pkg::TIME_W-1:0]        out_interval_us,
  // Control
  input  tpr_pkg::tpr_cmd_t                 cmd,
  output tpr_pkg::tpr_sts_t                 sts
);

  localparam int unsigned TW = tpr_pkg::TIME_W;
  localparam int unsigned DB = tpr_pkg::DIV_BITS;

  // Configuration registers.
  logic [tpr_pkg::MIN_IV_W-1:0]  min_iv_r;
  logic [tpr_pkg::RPM_W-1:0]     max_rpm_r;
  logic [tpr_pkg::TIMEOUT_W-1:0] timeout_r;
  logic                          cfg_wr;
  logic [1:0]                    reg_idx;

  // Captured transaction and persistent edge state.
  logic                          act_r;
  logic [TW-1:0]                 time_r;
  logic [TW-1:0]                 last_edge_r;
  logic                          seen_r;
  logic [TW-1:0]                 interval_r;
  logic [tpr_pkg::COUNT_W-1:0]   count_r;
  logic [tpr_pkg::RPM_W-1:0]     speed_r;
  logic [TW-1:0]                 since;

  // Divider.
  logic [TW:0]                    rem_r;
  logic [DB-1:0]                  quo_r;
  logic [TW-1:0]                  dvs_r;
  logic [tpr_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [TW:0]                    trial;
  logic                           fits;
  logic [tpr_pkg::RPM_W-1:0]      clamped;

  // Output register.
  logic                           out_valid_r;
  logic [tpr_pkg::RPM_W-1:0]      out_rpm_r;
  logic                           out_running_r;
  logic [tpr_pkg::COUNT_W-1:0]    out_count_r;
  logic [TW-1:0]                  out_iv_r;

  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Register read-back.
  always_comb begin
    unique case (reg_idx)
      tpr_pkg::REG_MIN_INTERVAL: prdata = tpr_pkg::APB_DATA_W'(min_iv_r);
      tpr_pkg::REG_MAX_RPM:      prdata = tpr_pkg::APB_DATA_W'(max_rpm_r);
      tpr_pkg::REG_STOP_TIMEOUT: prdata = tpr_pkg::APB_DATA_W'(timeout_r);
      default:                   prdata = '0;
    endcase
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_iv_r  <= tpr_pkg::MIN_IV_RESET;
      max_rpm_r <= tpr_pkg::MAX_RPM_RESET;
      timeout_r <= tpr_pkg::TIMEOUT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        tpr_pkg::REG_MIN_INTERVAL: min_iv_r  <= pwdata[tpr_pkg::MIN_IV_W-1:0];
        tpr_pkg::REG_MAX_RPM:      max_rpm_r <= pwdata[tpr_pkg::RPM_W-1:0];
        tpr_pkg::REG_STOP_TIMEOUT: timeout_r <= pwdata[tpr_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Time since the last edge, modulo the timestamp range.
  assign since = time_r - last_edge_r;

  assign sts.is_poll   = (act_r == tpr_pkg::ACT_POLL);
  assign sts.edge_seen = seen_r;
  assign sts.ge_min    = (since >= TW'(min_iv_r));
  assign sts.div_done  = (cnt_r == tpr_pkg::DIV_LAST);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Capture of the incoming transaction.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      time_r <= in_time_us;
    end
  end

  // Restoring division step: shift in one dividend bit, subtract if it fits.
  assign trial = {rem_r[TW-1:0], quo_r[DB-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // Quotient clamped to the maximum speed; a zero period gives zero.
  always_comb begin
    priority if (dvs_r == '0) begin
      clamped = '0;
    end else if (quo_r > DB'(max_rpm_r)) begin
      clamped = max_rpm_r;
    end else begin
      clamped = quo_r[tpr_pkg::RPM_W-1:0];
    end
  end

  // Edge state, speed and divider registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      seen_r      <= 1'b0;
      interval_r  <= '0;
      count_r     <= '0;
      speed_r     <= '0;
    end else begin
      if (cmd.poll_upd && (since > TW'(timeout_r))) begin
        speed_r <= '0;
      end
      if (cmd.first_edge) begin
        seen_r <= 1'b1;
      end
      if (cmd.first_edge || cmd.accept) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.first_edge || cmd.reject || cmd.accept) begin
        last_edge_r <= time_r;
      end
      if (cmd.accept) begin
        interval_r <= since;
      end
      if (cmd.clamp) begin
        speed_r <= clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem_r <= '0;
      quo_r <= tpr_pkg::RPM_NUMERATOR;
      dvs_r <= since;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= fits ? (trial - {1'b0, dvs_r}) : trial;
      quo_r <= {quo_r[DB-2:0], fits};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Output register; a new result may be loaded as the old one leaves.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_rpm_r     <= speed_r;
      out_running_r <= (speed_r != '0);
      out_count_r   <= count_r;
      out_iv_r      <= interval_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rpm         = out_rpm_r;
  assign out_running     = out_running_r;
  assign out_pulse_count = out_count_r;
  assign out_interval_us = out_iv_r;

endmodule

@@ rtl/core/tachometer_period_rpm.sv @@
// Top level of the one-pulse-per-revolution period tachometer.
// Depends on tpr_pkg, tpr_ctrl and tpr_dp.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_ready  in_action, in_time_us
//   out_     output     out_valid/out_ready out_rpm, out_running,
//                                          out_pulse_count, out_interval_us
//   config   input      psel/penable       paddr, pwdata, prdata (APB)
//
// A poll, first edge or debounced edge goes from evaluation to hand-over;
// a measured edge passes the 26-step serial restoring divider and clamp.
// One transaction is in work at a time; the next is taken once the result
// sits in the output register, even while that result waits for out_ready.
// Reset is synchronous, active low, and clears the edge state and speed.
// A stalled output holds the block in its hand-over state.
module tachometer_period_rpm (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpr_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [tpr_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tpr_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_action,
  input  logic [tpr_pkg::TIME_W-1:0]        in_time_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tpr_pkg::RPM_W-1:0]         out_rpm,
  output logic                              out_running,
  output logic [tpr_pkg::COUNT_W-1:0]       out_pulse_count,
  output logic [tpr_pkg::TIME_W-1:0]        out_interval_us
);

  tpr_pkg::tpr_cmd_t cmd;
  tpr_pkg::tpr_sts_t sts;

  // Configuration accesses complete without wait states.
  assign pready = 1'b1;

  tpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .in_action       (in_action),
    .in_time_us      (in_time_us),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_rpm         (out_rpm),
    .out_running     (out_running),
    .out_pulse_count (out_pulse_count),
    .out_interval_us (out_interval_us),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
